// File: hw/rtl/text_console_writer_unit_assert.svh
// Assertion macros for the text console writer checker.
// Depends on nothing; included by the checker file only.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication: when cond holds, chk must hold in that cycle.
`define TCW_ASSERT_IMPLY(label, clk, cond, chk) \
   label: assert property (@(posedge clk) (cond) |-> (chk)) \
      else $error("tcw: same-cycle check failed");

// Next-cycle implication: when cond holds, chk must hold in the next cycle.
`define TCW_ASSERT_NEXT(label, clk, cond, chk) \
   label: assert property (@(posedge clk) (cond) |=> (chk)) \
      else $error("tcw: next-cycle check failed");

`endif

// File: hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; imported by the front end, queue, back end and top level.
package tcw_pkg;

   // Operation codes of an input beat.
   localparam logic [1:0] OP_PUT       = 2'd0;
   localparam logic [1:0] OP_BACKSPACE = 2'd1;
   localparam logic [1:0] OP_READ      = 2'd2;

   // Character and attribute constants.
   localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0]  CHAR_BLANK   = 8'h20;
   localparam logic [7:0]  RESET_COLOR  = 8'h0F;
   localparam logic [15:0] RESET_ENTRY  = {RESET_COLOR, CHAR_BLANK};

   // Register index of the colour register on the configuration port.
   localparam logic [1:0] REG_TEXT_COLOR = 2'd0;

   // Widest cell address the parameter ranges allow (64 rows of 128 columns).
   localparam int MAX_ADDR_W = 13;

   // Kinds of work handed from the front end to the back end.
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // One classified command in the queue.
   typedef struct packed {
      logic [1:0]            kind;
      logic [MAX_ADDR_W-1:0] addr;
      logic [15:0]           entry;
      logic [10:0]           cursor_index;
      logic                  scrolled;
      logic [MAX_ADDR_W-1:0] blank_base;
      logic [7:0]            blank_attr;
   } tcw_cmd_type;

endpackage

// File: hw/rtl/tcw_front.sv
// Front end: owns the cursor and the scroll offset, classifies each beat.
// Depends on tcw_pkg; feeds tcw_queue.
module tcw_front
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [1:0]  op,
   input  logic [7:0]  char_code,
   input  logic [10:0] cell_index,
   input  logic [7:0]  text_color,
   output tcw_cmd_type cmd
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int XW    = ((AW > 11) ? AW : 11) + 1;

   localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
   localparam logic [AW-1:0] BOTTOM_LIN = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
   localparam logic [AW:0]   CELLS_P    = (AW + 1)'(CELLS);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] lin_ff, lin_in;
   logic [AW-1:0] top_ff, top_in;

   logic [1:0]    kind;
   logic [15:0]   entry;
   logic          scroll;
   logic          wrap_row;
   logic [AW-1:0] tgt;
   logic [AW-1:0] lin_dec;
   logic          in_range;
   logic [AW:0]   phys_sum;
   logic [AW-1:0] phys;
   logic [AW:0]   top_sum;
   logic [AW-1:0] top_wrap;
   logic [AW+10:0] lin_wide;

   assign lin_dec  = lin_ff - AW'(1);
   assign in_range = XW'(cell_index) < XW'(CELLS);

   // The top row advances round the circular screen buffer on each scroll.
   assign top_sum  = {1'b0, top_ff} + (AW + 1)'(COLUMNS);
   assign top_wrap = (top_sum >= CELLS_P) ? AW'(top_sum - CELLS_P) : AW'(top_sum);

   // Classify the beat and work out the cursor after it.
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      lin_in   = lin_ff;
      top_in   = top_ff;
      kind     = CMD_NONE;
      entry    = 16'h0000;
      scroll   = 1'b0;
      wrap_row = 1'b0;
      tgt      = lin_ff;
      case (op)
         OP_PUT: begin
            if (char_code == CHAR_NEWLINE) begin
               wrap_row = 1'b1;
            end else begin
               kind  = CMD_WRITE;
               entry = {text_color, char_code};
               if (col_ff == LAST_COL) begin
                  wrap_row = 1'b1;
               end else begin
                  col_in = col_ff + CW'(1);
                  lin_in = lin_ff + AW'(1);
               end
            end
         end
         OP_BACKSPACE: begin
            if (col_ff != '0) begin
               col_in = col_ff - CW'(1);
               lin_in = lin_dec;
               tgt    = lin_dec;
               kind   = CMD_WRITE;
               entry  = {text_color, CHAR_BLANK};
            end else if (row_ff != '0) begin
               row_in = row_ff - RW'(1);
               col_in = LAST_COL;
               lin_in = lin_dec;
               tgt    = lin_dec;
               kind   = CMD_WRITE;
               entry  = {text_color, CHAR_BLANK};
            end
         end
         OP_READ: begin
            tgt = AW'(XW'(cell_index));
            if (in_range) begin
               kind = CMD_READ;
            end
         end
         default: begin
         end
      endcase
      // Moving to the next row; past the last row the screen scrolls.
      if (wrap_row) begin
         col_in = '0;
         if (row_ff == LAST_ROW) begin
            scroll = 1'b1;
            lin_in = BOTTOM_LIN;
            top_in = top_wrap;
         end else begin
            row_in = row_ff + RW'(1);
            lin_in = lin_ff - AW'(col_ff) + COLS_A;
         end
      end
   end

   // Logical cell to physical address, rotated by the top row offset.
   assign phys_sum = {1'b0, tgt} + {1'b0, top_ff};
   assign phys     = (phys_sum >= CELLS_P) ? AW'(phys_sum - CELLS_P) : AW'(phys_sum);
   assign lin_wide = (AW + 11)'(lin_in);

   assign cmd.kind         = kind;
   assign cmd.addr         = MAX_ADDR_W'(phys);
   assign cmd.entry        = entry;
   assign cmd.cursor_index = lin_wide[10:0];
   assign cmd.scrolled     = scroll;
   assign cmd.blank_base   = MAX_ADDR_W'(top_ff);
   assign cmd.blank_attr   = text_color;

   // Cursor and offset registers move only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         lin_ff <= '0;
         top_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         lin_ff <= lin_in;
         top_ff <= top_in;
      end
   end

endmodule

// File: hw/rtl/tcw_queue.sv
// Short command queue between the front end and the back end.
// Depends on tcw_pkg for the command type.
module tcw_queue
   import tcw_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  tcw_cmd_type push_cmd,
   input  logic        pop,
   output tcw_cmd_type head,
   output logic        empty,
   output logic        full
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   tcw_cmd_type   slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == NW'(DEPTH));
   assign head  = slots_ff[rd_ptr_ff];

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hw/rtl/tcw_back.sv
// Back end: holds the screen memory, runs the clearing pass, writes,
// reads and row blanking, and drives the result beat. Depends on tcw_pkg.
module tcw_back
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        empty,
   input  tcw_cmd_type head,
   output logic        pop,
   output logic        clearing,
   output logic        rsp_strobe,
   output logic [15:0] rsp_cell_entry,
   output logic [10:0] rsp_cursor_index,
   output logic        rsp_scrolled
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);

   localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_BLANK = 2'd3;

   logic [15:0] screen_mem [CELLS];
   logic [15:0] rd_data_ff;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] blank_ff, blank_in;
   logic [7:0]    attr_ff, attr_in;
   logic [10:0]   hold_cursor_ff, hold_cursor_in;
   logic          hold_scrolled_ff, hold_scrolled_in;
   logic          strobe_ff, strobe_in;
   logic [15:0]   entry_ff, entry_in;
   logic [10:0]   cursor_ff, cursor_in;
   logic          scrolled_ff, scrolled_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic [AW-1:0] head_addr;

   assign head_addr = AW'(head.addr);
   assign pop       = (state_ff == ST_RUN) && !empty;
   assign clearing  = (state_ff == ST_CLEAR);

   // Sequencer for clearing, commands and row blanking.
   always_comb begin
      state_in         = state_ff;
      clr_in           = clr_ff;
      cnt_in           = cnt_ff;
      blank_in         = blank_ff;
      attr_in          = attr_ff;
      hold_cursor_in   = hold_cursor_ff;
      hold_scrolled_in = hold_scrolled_ff;
      strobe_in        = 1'b0;
      entry_in         = entry_ff;
      cursor_in        = cursor_ff;
      scrolled_in      = scrolled_ff;
      wr_en            = 1'b0;
      wr_addr          = clr_ff;
      wr_data          = RESET_ENTRY;
      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_CELL) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (pop) begin
               hold_cursor_in   = head.cursor_index;
               hold_scrolled_in = head.scrolled;
               attr_in          = head.blank_attr;
               blank_in         = AW'(head.blank_base);
               cnt_in           = '0;
               entry_in         = head.entry;
               if (head.kind == CMD_WRITE) begin
                  wr_en   = 1'b1;
                  wr_addr = head_addr;
                  wr_data = head.entry;
               end
               if (head.kind == CMD_READ) begin
                  state_in = ST_READ;
               end else if (head.scrolled) begin
                  state_in = ST_BLANK;
               end else begin
                  strobe_in   = 1'b1;
                  cursor_in   = head.cursor_index;
                  scrolled_in = head.scrolled;
               end
            end
         end
         ST_READ: begin
            strobe_in   = 1'b1;
            entry_in    = rd_data_ff;
            cursor_in   = hold_cursor_ff;
            scrolled_in = hold_scrolled_ff;
            state_in    = ST_RUN;
         end
         ST_BLANK: begin
            wr_en   = 1'b1;
            wr_addr = blank_ff + AW'(cnt_ff);
            wr_data = {attr_ff, CHAR_BLANK};
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == LAST_COL) begin
               strobe_in   = 1'b1;
               cursor_in   = hold_cursor_ff;
               scrolled_in = hold_scrolled_ff;
               state_in    = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt_ff           <= cnt_in;
      blank_ff         <= blank_in;
      attr_ff          <= attr_in;
      hold_cursor_ff   <= hold_cursor_in;
      hold_scrolled_ff <= hold_scrolled_in;
      entry_ff         <= entry_in;
      cursor_ff        <= cursor_in;
      scrolled_ff      <= scrolled_in;
   end

   // Screen memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= screen_mem[head_addr];
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_cell_entry   = entry_ff;
   assign rsp_cursor_index = cursor_ff;
   assign rsp_scrolled     = scrolled_ff;

endmodule

// File: hw/rtl/text_console_writer_unit.sv
// Top level of the text console writer: configuration port and wiring.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
// Usage:
// - Input beats: drive req_op, req_char_code and req_cell_index with start
//   high; the beat is taken at a rising edge where busy is low.
// - Results: one beat per input beat, shown for one cycle with rsp_strobe
//   high, in input order. The receiver cannot hold results off.
// - Result path: a put, backspace or no-op goes through the queue and the
//   result register; a read also goes through the registered memory read.
//   A step that scrolls also waits while the new bottom row is blanked.
// - Throughput: puts and backspaces sustain one beat per cycle while busy
//   stays low; the back end takes no new command while it returns a read.
//   A scroll holds the back end while the new bottom row is blanked; the
//   queue of QUEUE_DEPTH commands lets the front keep accepting until full.
// - Reset: the cursor goes to the origin, the colour to 0x0F, and the back
//   end then fills all ROWS * COLUMNS cells with a white blank, one cell a
//   cycle, with busy high throughout.
// - Configuration: the user must write the colour register at byte address 0
//   over the APB-style port only while idle; the block does not enforce it.
module text_console_writer_unit
   import tcw_pkg::*;
#(
   parameter int COLUMNS     = 80,
   parameter int ROWS        = 25,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_strobe,
   output logic [15:0] rsp_cell_entry,
   output logic [10:0] rsp_cursor_index,
   output logic        rsp_scrolled,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [7:0]  text_color_ff, text_color_in;
   logic        accept;
   logic        q_empty;
   logic        q_full;
   logic        pop;
   logic        clearing;
   tcw_cmd_type push_cmd;
   tcw_cmd_type head;

   // Configuration register.
   assign pready = 1'b1;
   assign text_color_in =
      (psel && penable && pwrite && (paddr == REG_TEXT_COLOR)) ? pwdata[7:0] : text_color_ff;
   assign prdata = (paddr == REG_TEXT_COLOR) ? {24'h000000, text_color_ff} : 32'h00000000;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_COLOR;
      end else begin
         text_color_ff <= text_color_in;
      end
   end

   // Beats are taken while the queue has room and the clearing pass is done.
   assign busy   = q_full || clearing;
   assign accept = start && !busy;

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (req_op),
      .char_code  (req_char_code),
      .cell_index (req_cell_index),
      .text_color (text_color_ff),
      .cmd        (push_cmd)
   );

   tcw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (q_empty),
      .head             (head),
      .pop              (pop),
      .clearing         (clearing),
      .rsp_strobe       (rsp_strobe),
      .rsp_cell_entry   (rsp_cell_entry),
      .rsp_cursor_index (rsp_cursor_index),
      .rsp_scrolled     (rsp_scrolled)
   );

endmodule

// File: hw/rtl/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on text_console_writer_unit_assert.svh for the assertion macros.
`include "text_console_writer_unit_assert.svh"

module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [10:0] rsp_cursor_index,
   input logic        rsp_scrolled
);

   // Cursor index at column zero of the bottom row, as the port shows it.
   localparam int          BOTTOM_FULL = (ROWS - 1) * COLUMNS;
   localparam logic [10:0] BOTTOM_IDX  = 11'(BOTTOM_FULL % 2048);

   // Reset starts the clearing pass, so no beat can be taken just after it.
   `TCW_ASSERT_NEXT(a_reset_busy, clock, reset, busy)

   // No result beat leaves the block straight after reset.
   `TCW_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_strobe)

   // A scrolling step always leaves the cursor at the start of the bottom row.
   `TCW_ASSERT_IMPLY(a_scroll_cursor, clock, !reset && rsp_strobe && rsp_scrolled,
                     rsp_cursor_index == BOTTOM_IDX)

endmodule

bind text_console_writer_unit tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_cursor_index (rsp_cursor_index),
   .rsp_scrolled     (rsp_scrolled)
);
